@@ sv/gemm_xd_pkg.sv @@
// ----------------------------------------------------------------------------
// gemm_xd_pkg
// Shared widths, register indexes and the step control word for the int8
// GEMM tile digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package gemm_xd_pkg;

	localparam int ROWS      = 8;
	localparam int BYTE_W    = 8;
	localparam int A_W       = ROWS * BYTE_W;
	localparam int B_W       = 64;
	localparam int TID_W     = 16;
	localparam int ACC_W     = 32;
	localparam int PROD_W    = 2 * BYTE_W;
	localparam int SLOT_W    = 32;
	localparam int CNT_W     = 16;
	localparam int CFG_AW    = 2;
	localparam int CFG_DW    = 16;
	localparam int IN_DATA_W  = A_W + B_W + TID_W;
	localparam int OUT_DATA_W = ACC_W + SLOT_W;

	localparam logic [CFG_AW-1:0] REG_BLOCKS_PER_TILE = 2'd0;
	localparam logic [CFG_AW-1:0] REG_TILE_TOTAL      = 2'd1;
	localparam logic [CFG_AW-1:0] REG_DIGEST_ENABLE   = 2'd2;

	typedef struct packed {
		logic valid;
		logic emit;
		logic clear;
	} step_ctl_t;

endpackage

`default_nettype wire

@@ sv/gemm_xd_ctrl.sv @@
// ----------------------------------------------------------------------------
// gemm_xd_ctrl
// Configuration registers, k-step and block counters; tags each accepted
// step with its emit flag (block end with digest enabled), its clear flag and its output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module gemm_xd_ctrl
	import gemm_xd_pkg::*;
#(
	parameter int K_PER_BLOCK = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [TID_W-1:0]  tile_id,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	output step_ctl_t              ctl,
	output logic      [SLOT_W-1:0] slot_index
);

	localparam int KW = $clog2(K_PER_BLOCK);
	localparam logic [KW-1:0] K_LAST = KW'(K_PER_BLOCK - 1);

	logic [KW-1:0]    k_q;
	logic [CNT_W-1:0] block_q;
	logic [CNT_W-1:0] blocks_per_tile_q;
	logic [CNT_W-1:0] tile_total_q;
	logic             digest_enable_q;

	logic             block_end;
	logic [CNT_W-1:0] block_next;
	logic [CNT_W-1:0] limit;
	logic             tile_done;

	always_comb begin
		block_end  = (k_q == K_LAST);
		block_next = block_q + CNT_W'(1);
		limit      = (blocks_per_tile_q == '0) ? CNT_W'(1) : blocks_per_tile_q;
		tile_done  = block_end && ((block_next >= limit) || (block_next == '0));
		ctl.valid  = accept;
		ctl.emit   = block_end && digest_enable_q;
		ctl.clear  = tile_done;
		slot_index = ({{(SLOT_W-CNT_W){1'b0}}, block_q} * {{(SLOT_W-CNT_W){1'b0}}, tile_total_q})
			+ {{(SLOT_W-TID_W){1'b0}}, tile_id};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			block_q <= '0;
		end else if (accept) begin
			k_q <= block_end ? '0 : k_q + KW'(1);
			if (block_end) begin
				block_q <= tile_done ? '0 : block_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_per_tile_q <= CNT_W'(1);
			tile_total_q      <= CNT_W'(1);
			digest_enable_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BLOCKS_PER_TILE: blocks_per_tile_q <= cfg_wdata;
				REG_TILE_TOTAL:      tile_total_q      <= cfg_wdata;
				REG_DIGEST_ENABLE:   digest_enable_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/gemm_xd_cell.sv @@
// ----------------------------------------------------------------------------
// gemm_xd_cell
// One tile column: eight int32 accumulators fed by the A column and the low
// byte of the B row; folds its column XOR into the running digest and hands
// the step on to the next column.
// ----------------------------------------------------------------------------
`default_nettype none

module gemm_xd_cell
	import gemm_xd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire step_ctl_t         ctl_in,
	input  wire logic [A_W-1:0]    a_in,
	input  wire logic [B_W-1:0]    b_in,
	input  wire logic [SLOT_W-1:0] slot_in,
	input  wire logic [ACC_W-1:0]  xor_in,
	output step_ctl_t              ctl_out,
	output logic      [A_W-1:0]    a_out,
	output logic      [B_W-1:0]    b_out,
	output logic      [SLOT_W-1:0] slot_out,
	output logic      [ACC_W-1:0]  xor_out
);

	logic        [ACC_W-1:0]  acc_q   [ROWS];
	logic        [ACC_W-1:0]  acc_new [ROWS];
	logic signed [PROD_W-1:0] prod    [ROWS];
	logic        [ACC_W-1:0]  xor_new;

	always_comb begin
		xor_new = xor_in;
		for (int r = 0; r < ROWS; r++) begin
			prod[r]    = $signed(a_in[r*BYTE_W +: BYTE_W]) * $signed(b_in[BYTE_W-1:0]);
			acc_new[r] = acc_q[r] + {{(ACC_W-PROD_W){prod[r][PROD_W-1]}}, prod[r]};
			xor_new    = xor_new ^ acc_new[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
			for (int r = 0; r < ROWS; r++) begin
				acc_q[r] <= '0;
			end
		end else if (en) begin
			ctl_out <= ctl_in;
			if (ctl_in.valid) begin
				for (int r = 0; r < ROWS; r++) begin
					acc_q[r] <= ctl_in.clear ? '0 : acc_new[r];
				end
			end
		end
	end

	// shift the B row down one byte for the next column
	always_ff @(posedge clk) begin
		if (en) begin
			a_out    <= a_in;
			b_out    <= {{BYTE_W{1'b0}}, b_in[B_W-1:BYTE_W]};
			slot_out <= slot_in;
			xor_out  <= xor_new;
		end
	end

endmodule

`default_nettype wire

@@ sv/int8_gemm_tile_xor_digest.sv @@
// ----------------------------------------------------------------------------
// int8_gemm_tile_xor_digest
// Int8 outer-product tile accumulator with a per-block XOR digest.
// ----------------------------------------------------------------------------
// Takes one k step per cycle while not stalled: a step enters the first
// column cell on the cycle it is accepted and moves one column per cycle
// along a row of COLS cells, each cell updating its eight accumulators and
// folding their XOR into the digest riding with the step. A block's digest
// passes through each column's registers into the output register. The
// input is stalled only while a result sits unaccepted in the output
// register. Columns past the eighth see a zero B byte and hold zero.
`default_nettype none

module int8_gemm_tile_xor_digest
	import gemm_xd_pkg::*;
#(
	parameter int COLS        = 8,
	parameter int K_PER_BLOCK = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// a_column [63:0], b_row [127:64], tile_id [143:128]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// xor_value [31:0], slot_index [63:32]
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_AW-1:0]     cfg_addr,
	input  wire logic [CFG_DW-1:0]     cfg_wdata
);

	logic              en;
	logic              accept;
	step_ctl_t         ctl_link  [COLS+1];
	logic [A_W-1:0]    a_link    [COLS+1];
	logic [B_W-1:0]    b_link    [COLS+1];
	logic [SLOT_W-1:0] slot_link [COLS+1];
	logic [ACC_W-1:0]  xor_link  [COLS+1];

	logic              out_valid_q;
	logic [ACC_W-1:0]  xor_value_q;
	logic [SLOT_W-1:0] slot_index_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && en;
	assign s_axis_tready = en;

	assign a_link[0]   = s_axis_tdata[A_W-1:0];
	assign b_link[0]   = s_axis_tdata[A_W+B_W-1:A_W];
	assign xor_link[0] = '0;

	gemm_xd_ctrl #(
		.K_PER_BLOCK(K_PER_BLOCK)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.tile_id   (s_axis_tdata[IN_DATA_W-1:A_W+B_W]),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl_link[0]),
		.slot_index(slot_link[0])
	);

	for (genvar c = 0; c < COLS; c++) begin : g_col
		gemm_xd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_link[c]),
			.a_in    (a_link[c]),
			.b_in    (b_link[c]),
			.slot_in (slot_link[c]),
			.xor_in  (xor_link[c]),
			.ctl_out (ctl_link[c+1]),
			.a_out   (a_link[c+1]),
			.b_out   (b_link[c+1]),
			.slot_out(slot_link[c+1]),
			.xor_out (xor_link[c+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_link[COLS].valid && ctl_link[COLS].emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xor_value_q  <= xor_link[COLS];
			slot_index_q <= slot_link[COLS];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {slot_index_q, xor_value_q};

endmodule

`default_nettype wire

@@ sv/gemm_xd_chk.sv @@
// ----------------------------------------------------------------------------
// gemm_xd_chk
// Port-level checks on the stream handshakes of the tile digest block.
// ----------------------------------------------------------------------------
`default_nettype none

module gemm_xd_chk
	import gemm_xd_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a waiting result");

	a_in_open_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |-> s_axis_tready)
		else $error("input stalled while result drains");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
		else $error("input transaction changed while stalled");

endmodule

bind int8_gemm_tile_xor_digest gemm_xd_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
